/* sv/calendar_date_add_days_core_assert.svh */
// Assertion macros for the calendar date adder core.
`ifndef CALENDAR_DATE_ADD_DAYS_CORE_ASSERT_SVH
`define CALENDAR_DATE_ADD_DAYS_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define CDAD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define CDAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cdad_pkg.sv */
// Shared types, constants and month-length function for the date adder.
package cdad_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef logic [1:0] status_t;

  localparam status_t StatusOk       = 2'd0;
  localparam status_t StatusInvalid  = 2'd1;
  localparam status_t StatusOverflow = 2'd2;

  localparam logic [3:0]  MonthJan = 4'd1;
  localparam logic [3:0]  MonthFeb = 4'd2;
  localparam logic [3:0]  MonthDec = 4'd12;
  localparam logic [15:0] YearMax  = 16'hFFFF;
  localparam logic [4:0]  DayLast  = 5'd31;

  // Days in a month; February has 29 only when the year is divisible by 4.
  function automatic logic [4:0] len_of(input logic [3:0] month, input logic [1:0] year_lsb);
    logic [4:0] len;
    case (month)
      4'd2:    len = (year_lsb == 2'd0) ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* sv/calendar_date_add_days_core.sv */
// Calendar date adder: start date plus a day count, walked one month per cycle.
//
// Input channel s_axis: one request carries day, month, year and a signed day
// count. Output channel m_axis: the resulting date with a status code in tuser
// (0 ok, 1 invalid start date, 2 year overflow saturated to 31/12/65535).
// An invalid start date returns 0/0/0; a negative count returns the start date.
// One request is in flight at a time; s_axis_tready_o is high only when idle.
// After accept the start date is checked; an invalid date or a negative
// count goes straight to the result, else the month-stepping loop (add,
// compare, subtract) walks the date forward one month boundary at a time
// until the count left falls within the current month or the year saturates.
// The result stays on m_axis until taken; a stalled sink holds the block busy.
// Reset clears the sequencer to idle with no result pending.
module calendar_date_add_days_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // in_day[4:0], in_month[8:5], in_year[24:9],
                                        // add_days[40:25], zero[47:41]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // out_day[4:0], out_month[8:5], out_year[24:9],
                                        // zero[31:25]
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);

  cdad_pkg::state_e  state_q, state_d;
  logic [4:0]        day_q, day_d;
  logic [3:0]        month_q, month_d;
  logic [15:0]       year_q, year_d;
  logic [15:0]       left_q, left_d;
  cdad_pkg::status_t status_q, status_d;

  logic [4:0]  len;
  logic [16:0] reach;
  logic        in_acc;
  logic        date_ok;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign len    = cdad_pkg::len_of(month_q, year_q[1:0]);
  assign reach  = {12'd0, day_q} + {1'b0, left_q};
  assign date_ok = (month_q >= cdad_pkg::MonthJan) && (month_q <= cdad_pkg::MonthDec)
                   && (day_q != 5'd0) && (day_q <= len);

  always_comb begin
    state_d  = state_q;
    day_d    = day_q;
    month_d  = month_q;
    year_d   = year_q;
    left_d   = left_q;
    status_d = status_q;
    case (state_q)
      cdad_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          day_d    = s_axis_tdata_i[4:0];
          month_d  = s_axis_tdata_i[8:5];
          year_d   = s_axis_tdata_i[24:9];
          left_d   = s_axis_tdata_i[40:25];
          status_d = cdad_pkg::StatusOk;
          state_d  = cdad_pkg::ST_CHECK;
        end
      end
      cdad_pkg::ST_CHECK: begin
        if (!date_ok) begin
          day_d    = 5'd0;
          month_d  = 4'd0;
          year_d   = 16'd0;
          status_d = cdad_pkg::StatusInvalid;
          state_d  = cdad_pkg::ST_DONE;
        end else if (left_q[15]) begin
          state_d = cdad_pkg::ST_DONE;
        end else begin
          state_d = cdad_pkg::ST_WALK;
        end
      end
      cdad_pkg::ST_WALK: begin
        if (reach <= {12'd0, len}) begin
          day_d   = reach[4:0];
          state_d = cdad_pkg::ST_DONE;
        end else begin
          left_d = left_q - {11'd0, len - day_q};
          day_d  = 5'd0;
          if (month_q < cdad_pkg::MonthDec) begin
            month_d = month_q + 4'd1;
          end else if (year_q == cdad_pkg::YearMax) begin
            day_d    = cdad_pkg::DayLast;
            month_d  = cdad_pkg::MonthDec;
            status_d = cdad_pkg::StatusOverflow;
            state_d  = cdad_pkg::ST_DONE;
          end else begin
            month_d = cdad_pkg::MonthJan;
            year_d  = year_q + 16'd1;
          end
        end
      end
      cdad_pkg::ST_DONE: begin
        if (m_axis_tready_i) begin
          state_d = cdad_pkg::ST_IDLE;
        end
      end
      default: state_d = cdad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdad_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q    <= day_d;
    month_q  <= month_d;
    year_q   <= year_d;
    left_q   <= left_d;
    status_q <= status_d;
  end

  assign s_axis_tready_o = (state_q == cdad_pkg::ST_IDLE);
  assign m_axis_tvalid_o = (state_q == cdad_pkg::ST_DONE);
  assign m_axis_tdata_o  = {7'd0, year_q, month_q, day_q};
  assign m_axis_tuser_o  = status_q;

`include "calendar_date_add_days_core_assert.svh"

  `CDAD_ASSERT_SAME(a_no_overlap, s_axis_tready_o, !m_axis_tvalid_o, "ready while result pending")
  `CDAD_ASSERT_NEXT(a_accept_check, in_acc, state_q == cdad_pkg::ST_CHECK,
    "accept did not start check")
  `CDAD_ASSERT_SAME(a_walk_month, state_q == cdad_pkg::ST_WALK,
    (month_q >= cdad_pkg::MonthJan) && (month_q <= cdad_pkg::MonthDec) && (day_q <= len)
    && !left_q[15], "walk state out of range")
  `CDAD_ASSERT_SAME(a_ok_result, m_axis_tvalid_o && (status_q == cdad_pkg::StatusOk),
    (day_q != 5'd0) && (month_q >= cdad_pkg::MonthJan) && (month_q <= cdad_pkg::MonthDec),
    "ok result is not a date")

endmodule
